// ===== rtl/nibble_rle_font_decoder_unit_assert.svh =====
// Assertion macros shared by the nibble RLE font decoder.
`ifndef NIBBLE_RLE_FONT_DECODER_UNIT_ASSERT_SVH
`define NIBBLE_RLE_FONT_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NRFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nrfd assertion failed");

// Next-cycle implication, checked outside reset.
`define NRFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nrfd assertion failed");

`endif

// ===== rtl/nrfd_pkg.sv =====
// Shared constants and control types of the nibble RLE font decoder.
`timescale 1ns / 1ps

package nrfd_pkg;

  // Field widths.
  localparam int unsigned CodeW  = 8;
  localparam int unsigned AlphaW = 8;
  localparam int unsigned CountW = 3;
  localparam int unsigned RunW   = 8;

  // Header byte layout: bit 7 set announces a literal run.
  localparam int unsigned HdrLitBit = 7;

  // Most pixel pairs carried by one output word.
  localparam logic [CountW-1:0] PairsPerWord = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;  // an input byte is accepted this cycle
    logic emit;  // a zero-run word is loaded into the output register
    logic busy;  // a zero run is being emitted
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;   // output register empty or being emptied
    logic zrun_hdr;    // the byte on the input is a zero-run header
    logic last_chunk;  // the remaining zero pairs fit in one word
  } status_t;

endpackage

// ===== rtl/nrfd_if.sv =====
// Valid/ready channel interfaces for the input bytes and the output words.
`timescale 1ns / 1ps

interface nrfd_in_if;
  logic                             valid;
  logic                             ready;
  logic [nrfd_pkg::CodeW-1:0]       code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

interface nrfd_out_if;
  logic                             valid;
  logic                             ready;
  logic [nrfd_pkg::AlphaW-1:0]      alpha_a;
  logic [nrfd_pkg::AlphaW-1:0]      alpha_b;
  logic [nrfd_pkg::AlphaW-1:0]      alpha_c;
  logic [nrfd_pkg::AlphaW-1:0]      alpha_d;
  logic [nrfd_pkg::AlphaW-1:0]      alpha_e;
  logic [nrfd_pkg::AlphaW-1:0]      alpha_f;
  logic [nrfd_pkg::AlphaW-1:0]      alpha_g;
  logic [nrfd_pkg::AlphaW-1:0]      alpha_h;
  logic [nrfd_pkg::CountW-1:0]      pair_count;
  logic                             end_of_burst;

  modport source (output valid, output alpha_a, output alpha_b, output alpha_c,
                  output alpha_d, output alpha_e, output alpha_f, output alpha_g,
                  output alpha_h, output pair_count, output end_of_burst,
                  input ready);
  modport sink (input valid, input alpha_a, input alpha_b, input alpha_c,
                input alpha_d, input alpha_e, input alpha_f, input alpha_g,
                input alpha_h, input pair_count, input end_of_burst,
                output ready);
endinterface

// ===== rtl/nrfd_ctrl.sv =====
// Controller of the nibble RLE font decoder: input acceptance and zero-run sequencing.
`timescale 1ns / 1ps

module nrfd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  nrfd_pkg::status_t st,
  output logic              in_ready,
  output nrfd_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_ZRUN = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Decide acceptance, emission and the next state.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = st.slot_free;
        cmd.take = in_valid && st.slot_free;
        if (cmd.take && st.zrun_hdr) begin
          state_nxt = S_ZRUN;
        end
      end
      S_ZRUN: begin
        cmd.busy = 1'b1;
        cmd.emit = st.slot_free;
        if (cmd.emit && st.last_chunk) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/nrfd_dp.sv =====
// Datapath of the nibble RLE font decoder: run state, zero-pair counter and output register.
`timescale 1ns / 1ps

module nrfd_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [nrfd_pkg::CodeW-1:0]     code_byte,
  input  logic                           out_ready,
  input  nrfd_pkg::cmd_t                 cmd,
  output nrfd_pkg::status_t              st,
  output logic                           out_valid,
  output logic [nrfd_pkg::AlphaW-1:0]    alpha_r [8],
  output logic [nrfd_pkg::CountW-1:0]    pair_count,
  output logic                           end_of_burst,
  output logic                           lit_data
);

  logic                          in_run_r, in_run_nxt;
  logic [nrfd_pkg::RunW-1:0]     left_r, left_nxt;
  logic [nrfd_pkg::RunW-1:0]     pairs_r, pairs_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [nrfd_pkg::CountW-1:0]   count_r;
  logic                          eob_r;
  logic                          load_lit;
  logic                          last_chunk;

  // Decode of the current byte against the run state.
  assign lit_data   = in_run_r && (left_r != '0);
  assign last_chunk = pairs_r <= nrfd_pkg::RunW'(nrfd_pkg::PairsPerWord);
  assign load_lit   = cmd.take && lit_data;

  assign st.slot_free  = !out_valid_r || out_ready;
  assign st.zrun_hdr   = !lit_data && !code_byte[nrfd_pkg::HdrLitBit];
  assign st.last_chunk = last_chunk;

  // Run state and zero-pair counter updates.
  always_comb begin
    in_run_nxt = in_run_r;
    left_nxt   = left_r;
    pairs_nxt  = pairs_r;
    if (cmd.take) begin
      if (lit_data) begin
        left_nxt   = left_r - 8'd1;
        in_run_nxt = (left_r != 8'd1);
      end else if (code_byte[nrfd_pkg::HdrLitBit]) begin
        in_run_nxt = 1'b1;
        left_nxt   = {1'b0, code_byte[6:0]} + 8'd1;
      end else begin
        in_run_nxt = 1'b0;
        left_nxt   = '0;
        pairs_nxt  = code_byte + 8'd2;
      end
    end else if (cmd.emit && !last_chunk) begin
      pairs_nxt = pairs_r - nrfd_pkg::RunW'(nrfd_pkg::PairsPerWord);
    end
  end

  // Output word valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (load_lit || cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r    <= 1'b0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_run_r    <= in_run_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers; a nibble times 17 is the nibble written twice.
  always_ff @(posedge clk) begin
    pairs_r <= pairs_nxt;
    if (load_lit) begin
      alpha_r[0] <= {code_byte[7:4], code_byte[7:4]};
      alpha_r[1] <= {code_byte[3:0], code_byte[3:0]};
      for (int i = 2; i < 8; i++) begin
        alpha_r[i] <= '0;
      end
      count_r    <= 3'd1;
      eob_r      <= 1'b1;
    end else if (cmd.emit) begin
      for (int i = 0; i < 8; i++) begin
        alpha_r[i] <= '0;
      end
      count_r <= last_chunk ? pairs_r[nrfd_pkg::CountW-1:0] : nrfd_pkg::PairsPerWord;
      eob_r   <= last_chunk;
    end
  end

  assign out_valid    = out_valid_r;
  assign pair_count   = count_r;
  assign end_of_burst = eob_r;

endmodule

// ===== rtl/nibble_rle_font_decoder_unit.sv =====
// Top level of the nibble RLE font decoder.
`timescale 1ns / 1ps

// Takes one compressed byte per input transfer and emits words of up to four pixel-alpha pairs.
// A literal data byte is accepted and its word is registered, available in the next cycle;
// a literal header is accepted and yields no word. A zero-run header b is accepted and
// then holds the input while its ceil((b + 2) / 4) output words are emitted,
// one at a time (1 to 33 words), since each word passes through the single output
// register; a stalled output holds the input longer. Unused pairs of a word read as 0,
// and end_of_burst marks the last word caused by a byte.
module nibble_rle_font_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  nrfd_in_if.sink    in_ch,
  nrfd_out_if.source out_ch
);

  `include "nibble_rle_font_decoder_unit_assert.svh"

  nrfd_pkg::cmd_t               cmd;
  nrfd_pkg::status_t            st;
  logic                         in_ready;
  logic                         lit_data;
  logic [nrfd_pkg::AlphaW-1:0]  alpha [8];

  // Controller.
  nrfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Datapath.
  nrfd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .code_byte    (in_ch.code_byte),
    .out_ready    (out_ch.ready),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_ch.valid),
    .alpha_r      (alpha),
    .pair_count   (out_ch.pair_count),
    .end_of_burst (out_ch.end_of_burst),
    .lit_data     (lit_data)
  );

  // Channel connections.
  assign in_ch.ready    = in_ready;
  assign out_ch.alpha_a = alpha[0];
  assign out_ch.alpha_b = alpha[1];
  assign out_ch.alpha_c = alpha[2];
  assign out_ch.alpha_d = alpha[3];
  assign out_ch.alpha_e = alpha[4];
  assign out_ch.alpha_f = alpha[5];
  assign out_ch.alpha_g = alpha[6];
  assign out_ch.alpha_h = alpha[7];

  // The input is held for the whole of a zero run.
  `NRFD_ASSERT_NOW(a_busy_blocks_input, cmd.busy, !in_ready)
  // Only the last word of a burst may be short.
  `NRFD_ASSERT_NOW(a_full_unless_last, out_ch.valid && !out_ch.end_of_burst, out_ch.pair_count == nrfd_pkg::PairsPerWord)
  // A literal data byte gives one single-pair closing word.
  `NRFD_ASSERT_NEXT(a_literal_word, cmd.take && lit_data, out_ch.valid && out_ch.pair_count == 3'd1 && out_ch.end_of_burst)
  // Emitting the last chunk ends the zero run.
  `NRFD_ASSERT_NEXT(a_run_ends, cmd.emit && st.last_chunk, !cmd.busy)

endmodule

// ===== test/nibble_rle_font_decoder_unit_test.sv =====
// Self-checking testbench for the nibble RLE font decoder: directed table, random stream.
`timescale 1ns / 1ps

module nibble_rle_font_decoder_unit_test;

  // Each nibble is scaled by this so that 0..15 spans 0..255.
  localparam int NibbleScale = 17;
  localparam int ScriptLen   = 20;
  localparam int RandomItems = 260;

  // One output word as the checker sees it; alpha[0] is alpha_a, alpha[7] is alpha_h.
  typedef struct packed {
    logic [7:0][nrfd_pkg::AlphaW-1:0] alpha;
    logic [nrfd_pkg::CountW-1:0]      pair_count;
    logic                             end_of_burst;
  } px_word_t;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    CHK_MODEL,   // expected words come from the decoder model
    CHK_SILENT,  // the byte is known to yield no word
    CHK_TYPED    // the byte yields exactly the one word typed in the row
  } row_check_t;

  typedef struct {
    logic [nrfd_pkg::CodeW-1:0] code;
    row_check_t                 check;
    px_word_t                   word;
  } script_row_t;

  logic clk;
  logic rst_n;

  nrfd_in_if  in_ch ();
  nrfd_out_if out_ch ();

  nibble_rle_font_decoder_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Decoder model state.
  logic                      lit_active;
  logic [nrfd_pkg::RunW-1:0] lit_remaining;

  px_word_t    fresh_words[$];
  px_word_t    expected_words[$];
  script_row_t script [ScriptLen];
  int          fail_count;
  logic        calm;

  string alpha_names [8] = '{"alpha_a", "alpha_b", "alpha_c", "alpha_d",
                             "alpha_e", "alpha_f", "alpha_g", "alpha_h"};

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A literal word with the given first pair, as typed into the table.
  function automatic px_word_t typed_word(input logic [7:0] a, input logic [7:0] b,
                                          input logic [nrfd_pkg::CountW-1:0] pairs);
    px_word_t w;
    w              = '0;
    w.alpha[0]     = a;
    w.alpha[1]     = b;
    w.pair_count   = pairs;
    w.end_of_burst = 1'b1;
    return w;
  endfunction

  // Decodes one accepted byte, updating the model state and leaving its words in fresh_words.
  function automatic void decode_code(input logic [nrfd_pkg::CodeW-1:0] code);
    px_word_t    w;
    int unsigned pairs_left;
    int unsigned n;
    fresh_words.delete();
    if (lit_active && lit_remaining != '0) begin
      w              = '0;
      w.alpha[0]     = 8'(int'(code[7:4]) * NibbleScale);
      w.alpha[1]     = 8'(int'(code[3:0]) * NibbleScale);
      w.pair_count   = nrfd_pkg::CountW'(1);
      w.end_of_burst = 1'b1;
      fresh_words.push_back(w);
      lit_remaining = lit_remaining - 1'b1;
      if (lit_remaining == '0) lit_active = 1'b0;
    end else if (code[nrfd_pkg::HdrLitBit]) begin
      lit_active    = 1'b1;
      lit_remaining = nrfd_pkg::RunW'(code[nrfd_pkg::HdrLitBit-1:0]) + 1'b1;
    end else begin
      // A zero run: full words of four pairs, the remainder in the last one.
      lit_active    = 1'b0;
      lit_remaining = '0;
      pairs_left    = int'(code) + 2;
      while (pairs_left > 0) begin
        n              = (pairs_left > nrfd_pkg::PairsPerWord) ? nrfd_pkg::PairsPerWord
                                                               : pairs_left;
        pairs_left     = pairs_left - n;
        w              = '0;
        w.pair_count   = nrfd_pkg::CountW'(n);
        w.end_of_burst = (pairs_left == 0);
        fresh_words.push_back(w);
      end
    end
  endfunction

  // Offers one byte after a random gap and returns once it has been accepted,
  // then records the words it is expected to cause.
  task automatic send_code(input logic [nrfd_pkg::CodeW-1:0] code, input row_check_t check,
                           input px_word_t typed);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid     <= 1'b0;
      in_ch.code_byte <= nrfd_pkg::CodeW'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.code_byte <= code;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    decode_code(code);
    case (check)
      CHK_MODEL: begin
        foreach (fresh_words[i]) expected_words.push_back(fresh_words[i]);
      end
      CHK_TYPED: begin
        expected_words.push_back(typed);
      end
      default: begin
      end
    endcase
  endtask

  // Sink side: a random stall before each word, none while calm.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Compares every accepted word with the oldest expectation, field by field.
  always @(posedge clk) begin
    px_word_t got;
    px_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.alpha = {out_ch.alpha_h, out_ch.alpha_g, out_ch.alpha_f, out_ch.alpha_e,
                   out_ch.alpha_d, out_ch.alpha_c, out_ch.alpha_b, out_ch.alpha_a};
      got.pair_count   = out_ch.pair_count;
      got.end_of_burst = out_ch.end_of_burst;
      if (expected_words.size() == 0) begin
        $error("unexpected output word: pair_count %0d, end_of_burst %0b",
               got.pair_count, got.end_of_burst);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (got.alpha[i] !== want.alpha[i]) begin
            $error("%s: expected %0d, got %0d", alpha_names[i], want.alpha[i], got.alpha[i]);
            fail_count++;
          end
        end
        if (got.pair_count !== want.pair_count) begin
          $error("pair_count: expected %0d, got %0d", want.pair_count, got.pair_count);
          fail_count++;
        end
        if (got.end_of_burst !== want.end_of_burst) begin
          $error("end_of_burst: expected %0b, got %0b", want.end_of_burst, got.end_of_burst);
          fail_count++;
        end
      end
    end
  end

  // Stimulus: directed table, then a random but well-formed stream.
  initial begin
    logic [nrfd_pkg::CodeW-1:0] code;
    int                         pick;
    int                         waited;
    fail_count      = 0;
    calm            = 1'b0;
    lit_active      = 1'b0;
    lit_remaining   = '0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.code_byte <= '0;

    script = '{
      // Zero runs: the shortest, partial words and the longest.
      '{8'h00, CHK_TYPED,  typed_word(8'd0, 8'd0, 3'd2)},
      '{8'h01, CHK_TYPED,  typed_word(8'd0, 8'd0, 3'd3)},
      '{8'h02, CHK_TYPED,  typed_word(8'd0, 8'd0, 3'd4)},
      '{8'h03, CHK_MODEL,  '0},
      '{8'h06, CHK_MODEL,  '0},
      '{8'h7F, CHK_MODEL,  '0},
      // Literal runs of one and two bytes with extreme nibbles.
      '{8'h80, CHK_SILENT, '0},
      '{8'hFF, CHK_TYPED,  typed_word(8'd255, 8'd255, 3'd1)},
      '{8'h80, CHK_SILENT, '0},
      '{8'h00, CHK_TYPED,  typed_word(8'd0, 8'd0, 3'd1)},
      '{8'h81, CHK_SILENT, '0},
      '{8'hF0, CHK_TYPED,  typed_word(8'd255, 8'd0, 3'd1)},
      '{8'h0F, CHK_TYPED,  typed_word(8'd0, 8'd255, 3'd1)},
      // Literal bytes that would read as headers outside a run.
      '{8'h83, CHK_SILENT, '0},
      '{8'h80, CHK_MODEL,  '0},
      '{8'h7F, CHK_MODEL,  '0},
      '{8'h5A, CHK_MODEL,  '0},
      '{8'hA5, CHK_MODEL,  '0},
      // A zero run that fills its last word exactly, then the longest literal run,
      // which the random part carries on with.
      '{8'h7E, CHK_MODEL,  '0},
      '{8'hFF, CHK_SILENT, '0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) send_code(script[r].code, script[r].check, script[r].word);

    // Mostly short literal runs and zero runs, with a long one now and then.
    for (int k = 0; k < RandomItems; k++) begin
      if ($urandom_range(0, 24) == 0) calm = ~calm;
      pick = $urandom_range(0, 9);
      if (lit_active) begin
        code = nrfd_pkg::CodeW'($urandom);
      end else if (pick < 4) begin
        code = 8'h80 | nrfd_pkg::CodeW'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 127)
                                                                     : $urandom_range(0, 7));
      end else if (pick < 9) begin
        code = nrfd_pkg::CodeW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                            : $urandom_range(0, 13));
      end else begin
        code = nrfd_pkg::CodeW'($urandom);
      end
      send_code(code, CHK_MODEL, '0);
    end
    in_ch.valid <= 1'b0;

    // A zero run can hold up to 33 words in flight, so drain and then wait a little longer.
    waited = 0;
    while (expected_words.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_words.size() != 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      fail_count++;
    end
    repeat (60) @(posedge clk);

    if (fail_count == 0) begin
      $display("nibble_rle_font_decoder_unit verification clean");
    end else begin
      $display("nibble_rle_font_decoder_unit verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("nibble_rle_font_decoder_unit verification failed");
    $finish;
  end

endmodule
